// ----- src/assert_macros.svh -----
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define GPM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gpm assertion failed");

// checked at every edge, reset included
`define GPM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gpm assertion failed");

`endif

// ----- src/gpm_pkg.sv -----
package gpm_pkg;

  localparam int unsigned ImageWidth  = 512;
  localparam int unsigned ImageHeight = 512;
  localparam int unsigned FramePixels = ImageWidth * ImageHeight;
  localparam int unsigned AddrW = (FramePixels > 1) ? $clog2(FramePixels) : 1;
  localparam int unsigned PosW  = $clog2(FramePixels + 1);

  localparam logic [4:0] FramesToCombineRst = 5'd10;
  localparam logic [3:0] FramesSkippedRst   = 4'd5;
  localparam logic [7:0] GreenMarginRst     = 8'd10;
  localparam logic [7:0] GreenFloorRst      = 8'd64;
  localparam logic [7:0] RedOn              = 8'd255;
  localparam logic [4:0] MaxCaptures        = 5'd16;

  typedef enum logic [1:0] {
    CfgFramesToCombine = 2'd0,
    CfgFramesSkipped   = 2'd1,
    CfgGreenMargin     = 2'd2,
    CfgGreenFloor      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0] frames_to_combine;
    logic [3:0] frames_skipped;
    logic [7:0] green_margin;
    logic [7:0] green_floor;
  } cfg_t;

  // per-pixel control handed from sequencer to mask pipeline
  typedef struct packed {
    logic             captured;
    logic             in_range;
    logic [AddrW-1:0] addr;
    logic             merge;
    logic             emit;
    logic             fend;
    logic             hit;
  } pix_ctrl_t;

endpackage

// ----- src/green_pixel_mask_over_frames.sv -----
// Green mask over a cycle of camera frames. One BGR pixel word is taken per clock
// unless the output stalls, and the block keeps up with an unbroken stream; the
// rate is set by the one-bit mask memory of 512 x 512 entries, read as a pixel
// enters and written back as it leaves the first stage, with a bypass when a
// pixel hits the entry written on the same edge. Only pixels of the last captured
// frame of a cycle give a result word; skip frames and earlier captures give
// none. The mask needs no clearing after reset: the first captured frame writes
// every entry it covers. Registers may be written only while the block is idle.
module green_pixel_mask_over_frames (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] blue_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_level_o,
  output logic       image_end_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  gpm_pkg::cfg_t      cfg_q, cfg_d;
  gpm_pkg::pix_ctrl_t pix;
  logic               acc;

  assign cfg_ready_o = 1'b1;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (gpm_pkg::cfg_idx_e'(cfg_index_i))
        gpm_pkg::CfgFramesToCombine: cfg_d.frames_to_combine = cfg_data_i[4:0];
        gpm_pkg::CfgFramesSkipped:   cfg_d.frames_skipped    = cfg_data_i[3:0];
        gpm_pkg::CfgGreenMargin:     cfg_d.green_margin      = cfg_data_i;
        gpm_pkg::CfgGreenFloor:      cfg_d.green_floor       = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frames_to_combine <= gpm_pkg::FramesToCombineRst;
      cfg_q.frames_skipped    <= gpm_pkg::FramesSkippedRst;
      cfg_q.green_margin      <= gpm_pkg::GreenMarginRst;
      cfg_q.green_floor       <= gpm_pkg::GreenFloorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gpm_frame_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .blue_i     (blue_i),
    .green_i    (green_i),
    .red_i      (red_i),
    .frame_end_i(frame_end_i),
    .cfg_i      (cfg_q),
    .pix_o      (pix)
  );

  gpm_mask_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .pix_i      (pix),
    .out_stall_i(out_stall_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .red_level_o(red_level_o),
    .image_end_o(image_end_o)
  );

endmodule

// ----- src/gpm_mask_ram.sv -----
module gpm_mask_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem_q [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/gpm_frame_seq.sv -----
module gpm_frame_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic [7:0]           blue_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           red_i,
  input  logic                 frame_end_i,
  input  gpm_pkg::cfg_t        cfg_i,
  output gpm_pkg::pix_ctrl_t   pix_o
);

  logic [gpm_pkg::PosW-1:0] pos_q, pos_d;
  logic [3:0] cap_q, cap_d;
  logic [3:0] skip_q, skip_d;
  logic       skip_phase_q, skip_phase_d;

  logic [4:0] eff;
  logic       last;
  logic [3:0] cap_next;
  logic [3:0] skip_next;
  logic       hit;

  always_comb begin
    if (cfg_i.frames_to_combine == 5'd0) begin
      eff = 5'd1;
    end else if (cfg_i.frames_to_combine > gpm_pkg::MaxCaptures) begin
      eff = gpm_pkg::MaxCaptures;
    end else begin
      eff = cfg_i.frames_to_combine;
    end
  end

  assign last      = ({1'b0, cap_q} + 5'd1) >= eff;
  assign cap_next  = last ? 4'd0 : cap_q + 4'd1;
  assign skip_next = skip_q + 4'd1;

  assign hit = ({1'b0, blue_i} + {1'b0, cfg_i.green_margin} < {1'b0, green_i})
             && ({1'b0, red_i} + {1'b0, cfg_i.green_margin} < {1'b0, green_i})
             && (green_i > cfg_i.green_floor);

  always_comb begin
    pix_o.captured = !skip_phase_q;
    pix_o.in_range = pos_q < gpm_pkg::PosW'(gpm_pkg::FramePixels);
    pix_o.addr     = pos_q[gpm_pkg::AddrW-1:0];
    pix_o.merge    = cap_q != 4'd0;
    pix_o.emit     = !skip_phase_q && last;
    pix_o.fend     = frame_end_i;
    pix_o.hit      = hit;
  end

  always_comb begin
    pos_d        = pos_q;
    cap_d        = cap_q;
    skip_d       = skip_q;
    skip_phase_d = skip_phase_q;
    if (acc_i) begin
      if (frame_end_i) begin
        pos_d = '0;
      end else if (pos_q < gpm_pkg::PosW'(gpm_pkg::FramePixels)) begin
        pos_d = pos_q + gpm_pkg::PosW'(1);
      end
      if (!skip_phase_q) begin
        if (frame_end_i) begin
          if (cfg_i.frames_skipped == 4'd0) begin
            cap_d = cap_next;
          end else begin
            skip_phase_d = 1'b1;
            skip_d       = 4'd0;
          end
        end
      end else if (frame_end_i) begin
        if (skip_next >= cfg_i.frames_skipped || skip_next == 4'd0) begin
          skip_phase_d = 1'b0;
          skip_d       = 4'd0;
          cap_d        = cap_next;
        end else begin
          skip_d = skip_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      cap_q        <= '0;
      skip_q       <= '0;
      skip_phase_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      cap_q        <= cap_d;
      skip_q       <= skip_d;
      skip_phase_q <= skip_phase_d;
    end
  end

endmodule

// ----- src/gpm_mask_pipe.sv -----
module gpm_mask_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  gpm_pkg::pix_ctrl_t pix_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output logic [7:0]         red_level_o,
  output logic               image_end_o
);

  logic               s1_v_q, s1_v_d;
  gpm_pkg::pix_ctrl_t s1_q;
  logic               fwd_hit_q;
  logic               fwd_data_q;
  logic               s2_v_q, s2_v_d;
  logic               s2_val_q;
  logic               s2_end_q;

  logic             rdata;
  logic             old_bit;
  logic             val;
  logic             s1_move;
  logic             we;
  logic             re;

  gpm_mask_ram #(
    .Depth(gpm_pkg::FramePixels),
    .AddrW(gpm_pkg::AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_q.addr),
    .wdata_i(val),
    .re_i   (re),
    .raddr_i(pix_i.addr),
    .rdata_o(rdata)
  );

  // bypass the write that lands on the same edge as the read
  assign old_bit = fwd_hit_q ? fwd_data_q : rdata;
  assign val     = s1_q.in_range && (s1_q.hit || (s1_q.merge && old_bit));
  assign s1_move = s1_v_q && (!s1_q.emit || !s2_v_q || !out_stall_i);
  assign in_stall_o = s1_v_q && !s1_move;
  assign we = s1_move && s1_q.captured && s1_q.in_range;
  assign re = acc_i && pix_i.captured && pix_i.in_range && pix_i.merge;

  always_comb begin
    s1_v_d = s1_v_q;
    if (acc_i) begin
      s1_v_d = 1'b1;
    end else if (s1_move) begin
      s1_v_d = 1'b0;
    end
    s2_v_d = s2_v_q;
    if (s1_move && s1_q.emit) begin
      s2_v_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q       <= pix_i;
      fwd_hit_q  <= we && (s1_q.addr == pix_i.addr);
      fwd_data_q <= val;
    end
    if (s1_move && s1_q.emit) begin
      s2_val_q <= val;
      s2_end_q <= s1_q.fend;
    end
  end

  assign out_valid_o = s2_v_q;
  assign red_level_o = s2_val_q ? gpm_pkg::RedOn : 8'd0;
  assign image_end_o = s2_end_q;

endmodule

// ----- src/gpm_checker.sv -----
`include "assert_macros.svh"

module gpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_level_o,
  input logic       image_end_o
);

  logic       out_hold;
  logic [8:0] out_word;

  assign out_hold = out_valid_o && out_stall_i;
  assign out_word = {red_level_o, image_end_o};

  `GPM_ASSERT(out_held_a, clk_i, rst_ni, out_hold |=> out_valid_o && $stable(out_word))
  `GPM_ASSERT(red_binary_a, clk_i, rst_ni, out_valid_o |-> red_level_o == 8'd0 || red_level_o == 8'd255)
  `GPM_ASSERT(no_in_stall_when_out_free_a, clk_i, rst_ni, !out_valid_o |-> !in_stall_o)
  `GPM_ASSERT_ALWAYS(quiet_in_reset_a, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o)

endmodule

bind green_pixel_mask_over_frames gpm_checker u_gpm_checker (.*);

// ----- bench/green_pixel_mask_over_frames_tb.sv -----
`timescale 1ns / 100ps

module green_pixel_mask_over_frames_tb;

  localparam int unsigned RandomPixels = 1400;
  localparam int unsigned QuietLimit   = 4000;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic       image_end;
  } mask_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] blue_i;
  logic [7:0] green_i;
  logic [7:0] red_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] red_level_o;
  logic       image_end_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  // mirror of the block state
  gpm_pkg::cfg_t            regs;
  bit                       mask_bits [gpm_pkg::FramePixels];
  logic [gpm_pkg::PosW-1:0] pixel_pos;
  logic [3:0]               capture_idx;
  logic [3:0]               skip_idx;
  logic                     skipping;
  int unsigned              covered_len;

  mask_word_t  mask_out_q [$];
  mask_word_t  want;
  int unsigned mismatch_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on = 1'b1;

  green_pixel_mask_over_frames dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .blue_i      (blue_i),
    .green_i     (green_i),
    .red_i       (red_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_level_o (red_level_o),
    .image_end_o (image_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 28);
  end

  task automatic track_green_mask(input logic [7:0] b, g, r, input logic fend);
    int unsigned eff;
    bit          last;
    bit          hit;
    bit          val;
    mask_word_t  w;
    if (regs.frames_to_combine == 0) eff = 1;
    else if (regs.frames_to_combine > gpm_pkg::MaxCaptures) eff = gpm_pkg::MaxCaptures;
    else eff = regs.frames_to_combine;
    last = (capture_idx + 1 >= eff);
    if (!skipping) begin
      hit = (int'(b) + int'(regs.green_margin) < int'(g)) &&
            (int'(r) + int'(regs.green_margin) < int'(g)) &&
            (g > regs.green_floor);
      val = 1'b0;
      if (pixel_pos < gpm_pkg::FramePixels) begin
        val = hit || (capture_idx != 0 && mask_bits[pixel_pos]);
        mask_bits[pixel_pos] = val;
        if (pixel_pos >= covered_len) covered_len = pixel_pos + 1;
      end
      if (last) begin
        w.red_level = val ? gpm_pkg::RedOn : 8'd0;
        w.image_end = fend;
        mask_out_q.push_back(w);
      end
      if (fend) begin
        if (regs.frames_skipped == 0) begin
          capture_idx = last ? 4'd0 : capture_idx + 4'd1;
        end else begin
          skipping = 1'b1;
          skip_idx = 4'd0;
        end
      end
    end else if (fend) begin
      skip_idx = skip_idx + 4'd1;
      // a lowered skip count ends the skip run early
      if (skip_idx >= regs.frames_skipped || skip_idx == 0) begin
        skipping = 1'b0;
        skip_idx = 4'd0;
        capture_idx = last ? 4'd0 : capture_idx + 4'd1;
      end
    end
    if (fend) pixel_pos = '0;
    else if (pixel_pos < gpm_pkg::FramePixels) pixel_pos = pixel_pos + 1'b1;
  endtask

  function automatic bgr_t make_pixel();
    bgr_t px;
    int   near;
    px.green = ($urandom_range(3) == 0) ? regs.green_floor + 8'($urandom_range(1))
                                        : 8'($urandom);
    near = int'(px.green) - int'(regs.green_margin) - int'($urandom_range(1));
    px.blue = (near >= 0 && $urandom_range(2) != 0) ? 8'(near) : 8'($urandom);
    near = int'(px.green) - int'(regs.green_margin) - int'($urandom_range(1));
    px.red = (near >= 0 && $urandom_range(2) != 0) ? 8'(near) : 8'($urandom);
    if ($urandom_range(3) == 0) px = 24'($urandom);
    return px;
  endfunction

  task automatic send_pixel(input logic [7:0] b, g, r, input logic fend);
    bit taken;
    while (gaps_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    blue_i      <= b;
    green_i     <= g;
    red_i       <= r;
    frame_end_i <= fend;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    pixels_sent++;
    track_green_mask(b, g, r, fend);
  endtask

  task automatic send_frame(input int unsigned len);
    bgr_t px;
    // later captures never reach past what earlier captures have written
    if (!skipping && capture_idx != 0 && len > covered_len) len = covered_len;
    for (int unsigned i = 0; i < len; i++) begin
      px = make_pixel();
      send_pixel(px.blue, px.green, px.red, i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (mask_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] combine, skipped, margin, floor_lvl);
    logic [7:0]        vals [4];
    gpm_pkg::cfg_idx_e idx;
    bit                taken;
    vals = '{combine, skipped, margin, floor_lvl};
    drain();
    for (int i = 0; i < 4; i++) begin
      idx = gpm_pkg::cfg_idx_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      do begin
        @(negedge clk_i);
        taken = cfg_ready_o;
        @(posedge clk_i);
      end while (!taken);
      case (idx)
        gpm_pkg::CfgFramesToCombine: regs.frames_to_combine = vals[i][4:0];
        gpm_pkg::CfgFramesSkipped:   regs.frames_skipped    = vals[i][3:0];
        gpm_pkg::CfgGreenMargin:     regs.green_margin      = vals[i];
        gpm_pkg::CfgGreenFloor:      regs.green_floor       = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_config();
    repeat (60) send_frame(1);
  endtask

  task automatic test_pixel_thresholds();
    set_regs(8'd1, 8'd0, 8'd10, 8'd64);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd65, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd64, 8'd0, 1'b0);
    send_pixel(8'd54, 8'd65, 8'd54, 1'b0);
    send_pixel(8'd55, 8'd65, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd65, 8'd55, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    // margin plus channel must not wrap
    set_regs(8'd1, 8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    set_regs(8'd1, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd0, 1'b1);
  endtask

  task automatic test_count_limits();
    // zero acts as one, upper bits of the word ignored
    set_regs(8'hE0, 8'hF0, 8'd10, 8'd64);
    repeat (2) send_frame(1);
    // seventeen acts as sixteen
    set_regs(8'hF1, 8'd0, 8'd10, 8'd64);
    repeat (17) send_frame(1);
  endtask

  task automatic test_lowered_count();
    set_regs(8'd4, 8'd0, 8'd10, 8'd64);
    repeat (2) send_frame(2);
    set_regs(8'd1, 8'd0, 8'd10, 8'd64);
    send_frame(2);
    send_frame(3);
  endtask

  task automatic test_lowered_skip();
    set_regs(8'd1, 8'd15, 8'd10, 8'd64);
    send_frame(2);
    repeat (3) send_frame(1);
    set_regs(8'd1, 8'd2, 8'd10, 8'd64);
    send_frame(1);
    send_frame(2);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    set_regs(8'd1, 8'd0, 8'd10, 8'd64);
    repeat (4) send_frame(50);
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int unsigned stop_at;
    int unsigned phase_end;
    logic [7:0]  combine, skipped, margin, floor_lvl;
    stop_at = pixels_sent + RandomPixels;
    while (pixels_sent < stop_at) begin
      combine   = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(4, 1));
      skipped   = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(2));
      margin    = ($urandom_range(4) == 0) ? 8'($urandom_range(1) * 255)
                                           : 8'($urandom_range(40));
      floor_lvl = ($urandom_range(4) == 0) ? 8'($urandom_range(1) * 255)
                                           : 8'($urandom_range(200));
      set_regs(combine, skipped, margin, floor_lvl);
      phase_end = pixels_sent + 100 + $urandom_range(100);
      while (pixels_sent < phase_end && pixels_sent < stop_at) begin
        if (skipping) send_frame($urandom_range(3, 1));
        else if ($urandom_range(9) == 0) send_frame($urandom_range(60, 20));
        else send_frame($urandom_range(12, 1));
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mask_out_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, got red_level %0d image_end %0b",
                 $time, red_level_o, image_end_o);
      end else begin
        want = mask_out_q.pop_front();
        if (red_level_o !== want.red_level) begin
          mismatch_count++;
          $display("%0t: red_level expected %0d got %0d", $time, want.red_level,
                   red_level_o);
        end
        if (image_end_o !== want.image_end) begin
          mismatch_count++;
          $display("%0t: image_end expected %0b got %0b", $time, want.image_end,
                   image_end_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    blue_i      = 8'd0;
    green_i     = 8'd0;
    red_i       = 8'd0;
    frame_end_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gpm_pkg::CfgFramesToCombine;
    cfg_data_i  = 8'd0;
    regs.frames_to_combine = gpm_pkg::FramesToCombineRst;
    regs.frames_skipped    = gpm_pkg::FramesSkippedRst;
    regs.green_margin      = gpm_pkg::GreenMarginRst;
    regs.green_floor       = gpm_pkg::GreenFloorRst;
    pixel_pos   = '0;
    capture_idx = 4'd0;
    skip_idx    = 4'd0;
    skipping    = 1'b0;
    covered_len = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_pixel_thresholds();
    test_count_limits();
    test_lowered_count();
    test_lowered_skip();
    test_back_to_back();
    test_random_streams();
    drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/gpm_pkg.sv
src/gpm_mask_ram.sv
src/gpm_frame_seq.sv
src/gpm_mask_pipe.sv
src/green_pixel_mask_over_frames.sv
src/gpm_checker.sv
bench/green_pixel_mask_over_frames_tb.sv
